[rtl/mfmd_pkg.sv]
// Shared types, register codes and sizes for the multiturn feedback decoder.
`timescale 1ns / 1ps

package mfmd_pkg;

    // Slot table and position accumulator sizes
    localparam int NUM_SLOTS = 5;
    localparam int POS_W     = 48;
    localparam int ADDR_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Fixed field widths
    localparam int KEY_W   = 12;
    localparam int SLOT_W  = 3;
    localparam int ANGLE_W = 16;
    localparam int SPEED_W = 16;
    localparam int TEMP_W  = 8;
    localparam int DELTA_W = 17;
    localparam int EN_W    = 5;
    localparam int CPR_W   = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY4   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CPR    = 3'd6;

    // Reset values
    localparam logic [KEY_W-1:0] KEY_RESET [6] = '{
        12'd520, 12'd517, 12'd518, 12'd2566, 12'd2565, 12'd0
    };
    localparam logic [EN_W-1:0]  ENABLE_RESET = 5'd31;
    localparam logic [CPR_W-1:0] CPR_RESET    = 16'd8192;

    // Per-slot state held in the slot memory
    typedef struct packed {
        logic [ANGLE_W-1:0]     angle;
        logic signed [POS_W-1:0] pos;
    } t_slot_state;

    // Slot memory access request
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_slot_state       wr_data;
    } t_mem_req;

    // Key lookup result
    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] slot;
    } t_match;

endpackage

[rtl/motor_feedback_multiturn_decoder_top.sv]
// Top level of the motor feedback multiturn decoder.
// Use: feedback frames enter on the s_ channel, one request per frame; each
// frame yields exactly one result request on the m_ channel, matched=0 with
// all other fields zero when no enabled slot key equals bus*2048+frame_id.
// Slot keys, slot enable and counts per revolution are written on the cfg
// port; the user must do so only while the block is idle, which it does not enforce.
// Path: a frame's key match and memory read load the update stage on accept;
// unwrap, accumulate and write back happen as it moves to the output register.
// Throughput: one frame per cycle unless m_ stalls; slot state memory is
// read on accept and written when the update leaves; a back-to-back hit
// on the same slot takes the just-computed state from a forwarding register.
// Reset: slot state reads as zero (per-entry valid bits), config registers
// return to their defaults, no result is pending. No clearing pass.
// Stall: while m_tready is low the result holds; one more frame may be taken
// into the update stage, after which s_tready drops until the result leaves.
`timescale 1ns / 1ps

module motor_feedback_multiturn_decoder_top
    import mfmd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Frame input
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // frame_id[10:0], data_byte0[18:11], data_byte1[26:19], data_byte2[34:27],
    // data_byte3[42:35], data_byte6[50:43], zero pad[55:51]
    input  logic [55:0]           i_s_tdata,
    // bus[0]
    input  logic [0:0]            i_s_tuser,
    // Result output
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // slot[2:0], angle_raw[18:3], speed_rpm[34:19], temperature[42:35],
    // angle_delta[59:43], position_sum[107:60], zero pad[111:108]
    output logic [111:0]          o_m_tdata,
    // matched[0]
    output logic [0:0]            o_m_tuser,
    // Configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [KEY_W-1:0] r_key [NUM_SLOTS];
    logic [EN_W-1:0]  r_enable;
    logic [CPR_W-1:0] r_cpr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_key[i] <= KEY_RESET[i];
            end
            r_enable <= ENABLE_RESET;
            r_cpr    <= CPR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx) inside
                [CFG_KEY0:CFG_KEY4]: begin
                    if (32'(i_cfg_idx) < NUM_SLOTS) begin
                        r_key[i_cfg_idx[ADDR_W-1:0]] <= i_cfg_data[KEY_W-1:0];
                    end
                end
                CFG_ENABLE: r_enable <= i_cfg_data[EN_W-1:0];
                CFG_CPR:    r_cpr    <= i_cfg_data[CPR_W-1:0];
                default: ;
            endcase
        end
    end

    // Key lookup on the incoming frame
    t_match in_match;

    mfmd_match u_match (
        .i_key      ({i_s_tuser[0], i_s_tdata[10:0]}),
        .i_slot_key (r_key),
        .i_enable   (r_enable),
        .o_match    (in_match)
    );

    // Handshake
    logic r_s1_valid;
    logic r_m_valid;
    logic s1_fire;
    logic in_fire;

    assign s1_fire    = r_s1_valid && (!r_m_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_fire;
    assign in_fire    = i_s_tvalid && o_s_tready;

    // Update stage registers
    logic               r_s1_hit;
    logic [ADDR_W-1:0]  r_s1_slot;
    logic [ANGLE_W-1:0] r_s1_angle;
    logic [SPEED_W-1:0] r_s1_speed;
    logic [TEMP_W-1:0]  r_s1_temp;
    logic               r_fwd;
    t_slot_state        r_fwd_data;

    t_slot_state               mem_q;
    t_slot_state               prev;
    t_slot_state               next_state;
    logic signed [DELTA_W-1:0] delta;
    t_mem_req                  mem_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
                // Same slot written at this edge: the memory read misses it
                r_fwd <= s1_fire && r_s1_hit && in_match.hit
                         && (r_s1_slot == in_match.slot);
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Angle and speed: byte0/byte2 are the high bytes
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_hit   <= in_match.hit;
            r_s1_slot  <= in_match.slot;
            r_s1_angle <= {i_s_tdata[18:11], i_s_tdata[26:19]};
            r_s1_speed <= {i_s_tdata[34:27], i_s_tdata[42:35]};
            r_s1_temp  <= i_s_tdata[50:43];
            r_fwd_data <= next_state;
        end
    end

    // Slot state memory: read on accept, write back when the update leaves
    always_comb begin
        mem_req.rd_en   = in_fire && in_match.hit;
        mem_req.rd_addr = in_match.slot;
        mem_req.wr_en   = s1_fire && r_s1_hit;
        mem_req.wr_addr = r_s1_slot;
        mem_req.wr_data = next_state;
    end

    mfmd_slot_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (mem_q)
    );

    assign prev = r_fwd ? r_fwd_data : mem_q;

    mfmd_update u_update (
        .i_prev  (prev),
        .i_angle (r_s1_angle),
        .i_cpr   (r_cpr),
        .o_delta (delta),
        .o_next  (next_state)
    );

    // Output register
    logic                      r_m_matched;
    logic [SLOT_W-1:0]         r_m_slot;
    logic [ANGLE_W-1:0]        r_m_angle;
    logic [SPEED_W-1:0]        r_m_speed;
    logic [TEMP_W-1:0]         r_m_temp;
    logic signed [DELTA_W-1:0] r_m_delta;
    logic signed [POS_W-1:0]   r_m_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s1_fire) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_m_matched <= r_s1_hit;
            if (r_s1_hit) begin
                r_m_slot  <= SLOT_W'(r_s1_slot);
                r_m_angle <= r_s1_angle;
                r_m_speed <= r_s1_speed;
                r_m_temp  <= r_s1_temp;
                r_m_delta <= delta;
                r_m_pos   <= next_state.pos;
            end else begin
                r_m_slot  <= '0;
                r_m_angle <= '0;
                r_m_speed <= '0;
                r_m_temp  <= '0;
                r_m_delta <= '0;
                r_m_pos   <= '0;
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_matched;
    assign o_m_tdata  = {4'b0000, r_m_pos, r_m_delta, r_m_temp, r_m_speed,
                         r_m_angle, r_m_slot};

endmodule

[rtl/mfmd_match.sv]
// Slot key lookup: lowest enabled slot whose key equals the frame key.
`timescale 1ns / 1ps

module mfmd_match
    import mfmd_pkg::*;
(
    input  logic [KEY_W-1:0] i_key,
    input  logic [KEY_W-1:0] i_slot_key [NUM_SLOTS],
    input  logic [EN_W-1:0]  i_enable,
    output t_match           o_match
);

    // Scan from the top so the lowest index wins
    always_comb begin
        o_match = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (i < EN_W) begin
                if (i_enable[i] && (i_slot_key[i] == i_key)) begin
                    o_match.hit  = 1'b1;
                    o_match.slot = ADDR_W'(i);
                end
            end
        end
    end

endmodule

[rtl/mfmd_slot_mem.sv]
// Slot state memory: registered synchronous read, valid bits give zero reset.
`timescale 1ns / 1ps

module mfmd_slot_mem
    import mfmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mem_req    i_req,
    output t_slot_state o_rd_data
);

    t_slot_state          r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_vld;
    t_slot_state          r_q;
    logic                 r_q_vld;

    // Storage array
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_q <= r_mem[i_req.rd_addr];
        end
    end

    // Per-entry valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                r_q_vld <= r_vld[i_req.rd_addr];
            end
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    // Never-written entries read as zero
    assign o_rd_data = r_q_vld ? r_q : '0;

endmodule

[rtl/mfmd_update.sv]
// Angle unwrap and saturating multiturn accumulate for one slot.
`timescale 1ns / 1ps

module mfmd_update
    import mfmd_pkg::*;
(
    input  t_slot_state               i_prev,
    input  logic [ANGLE_W-1:0]        i_angle,
    input  logic [CPR_W-1:0]          i_cpr,
    output logic signed [DELTA_W-1:0] o_delta,
    output t_slot_state               o_next
);

    logic signed [DELTA_W:0] diff;
    logic signed [DELTA_W:0] wrapped;
    logic signed [DELTA_W:0] rev;
    logic signed [DELTA_W:0] half;
    logic signed [POS_W:0]   sum;

    // Raw difference, then wrap by one revolution past half a turn
    always_comb begin
        rev  = $signed({2'b00, i_cpr});
        half = $signed({3'b000, i_cpr[CPR_W-1:1]});
        diff = $signed({2'b00, i_angle}) - $signed({2'b00, i_prev.angle});
        if (diff < -half) begin
            wrapped = diff + rev;
        end else if (diff > half) begin
            wrapped = diff - rev;
        end else begin
            wrapped = diff;
        end
    end

    // Add with one guard bit, clamp on overflow
    always_comb begin
        sum = $signed({i_prev.pos[POS_W-1], i_prev.pos}) + (POS_W+1)'(wrapped);
        o_next.angle = i_angle;
        if (sum[POS_W] != sum[POS_W-1]) begin
            o_next.pos = sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                    : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            o_next.pos = sum[POS_W-1:0];
        end
        o_delta = wrapped[DELTA_W-1:0];
    end

endmodule
